// ----- rtl/multiset_combination_stepper_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Multiset combination stepper assertion macros
// Shared property forms used by the stepper's assertions.
// ----------------------------------------------------------------------------
`ifndef MULTISET_COMBINATION_STEPPER_UNIT_MACROS_SVH
`define MULTISET_COMBINATION_STEPPER_UNIT_MACROS_SVH

// same-cycle implication
`define MCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/mcs_pkg.sv -----
// ----------------------------------------------------------------------------
// Multiset combination stepper package
// Request/response payloads, cell control bundle and codes.
// ----------------------------------------------------------------------------
package mcs_pkg;

  localparam int LANE_BITS = 8;
  localparam int IDX_BITS  = 3;
  localparam int LEN_BITS  = 4;
  localparam int VC_BITS   = 9;
  localparam int CFG_IDX_BITS = 2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_DONE = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] REG_VALUE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TUPLE_LENGTH = 2'd1;

  typedef struct packed {
    logic                 cmd;
    logic [IDX_BITS-1:0]  elem_index;
    logic [LANE_BITS-1:0] elem_value;
  } req_t;

  typedef struct packed {
    logic [63:0] tuple_packed;
    logic        status;
  } rsp_t;

  // broadcast to every cell
  typedef struct packed {
    logic                 step;
    logic                 load;
    logic [IDX_BITS-1:0]  idx;
    logic [LANE_BITS-1:0] val;
    logic [LANE_BITS-1:0] max_val;
    logic [LEN_BITS-1:0]  len;
  } cell_ctrl_t;

  // fill value handed left to right
  typedef struct packed {
    logic                 on;
    logic [LANE_BITS-1:0] val;
  } fill_t;

endpackage

// ----- rtl/multiset_combination_stepper_unit.sv -----
// An accepted request has its response in the output register in the next cycle.
// Throughput: 1 request per cycle while no response is stalled; a request is taken
// while the previous response is being taken, since req_stall follows rsp_stall.
// The cell chain resolves pivot search and fill combinationally (MAX_K-cell ripple, 8 by default).
// Reset (rst, synchronous): all elements zero, value_count 256, tuple_length 8,
// no response pending.
// ----------------------------------------------------------------------------
// Multiset combination stepper
// Loads elements and steps a nondecreasing tuple to the next combination with repetition.
// ----------------------------------------------------------------------------
`include "multiset_combination_stepper_unit_macros.svh"

module multiset_combination_stepper_unit #(
  parameter int MAX_K     = 8,
  parameter int ELEM_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  output logic                                 req_stall,
  input  mcs_pkg::req_t                        req,
  output logic                                 rsp_valid,
  input  logic                                 rsp_stall,
  output mcs_pkg::rsp_t                        rsp,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mcs_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [mcs_pkg::VC_BITS-1:0]          cfg_data
);

  localparam logic [mcs_pkg::VC_BITS-1:0] VC_CAP = mcs_pkg::VC_BITS'(1 << ELEM_BITS);

  logic [mcs_pkg::VC_BITS-1:0]  value_count;
  logic [mcs_pkg::LEN_BITS-1:0] tuple_length;
  logic [mcs_pkg::VC_BITS-1:0]  vc_sat;
  logic [mcs_pkg::VC_BITS-1:0]  max_wide;
  logic [mcs_pkg::LEN_BITS-1:0] len_eff;
  logic                         accept;
  logic                         done;
  logic                         rsp_valid_next;

  mcs_pkg::cell_ctrl_t                      ctrl;
  logic [MAX_K:0]                           below_chain;
  mcs_pkg::fill_t [MAX_K:0]                 fill_chain;
  logic [MAX_K-1:0][mcs_pkg::LANE_BITS-1:0] lanes_next;
  logic [MAX_K-1:0][mcs_pkg::LANE_BITS-1:0] lanes_out;
  logic [MAX_K-1:0][mcs_pkg::LANE_BITS-1:0] lanes_now;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      value_count  <= mcs_pkg::VC_BITS'(256);
      tuple_length <= mcs_pkg::LEN_BITS'(8);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == mcs_pkg::REG_VALUE_COUNT) begin
        value_count <= cfg_data;
      end else if (cfg_index == mcs_pkg::REG_TUPLE_LENGTH) begin
        tuple_length <= cfg_data[mcs_pkg::LEN_BITS-1:0];
      end
    end
  end

  // effective maximum value and tuple length
  always_comb begin
    if (value_count == '0) begin
      vc_sat = mcs_pkg::VC_BITS'(1);
    end else if (value_count > VC_CAP) begin
      vc_sat = VC_CAP;
    end else begin
      vc_sat = value_count;
    end
    max_wide = vc_sat - mcs_pkg::VC_BITS'(1);
    if (tuple_length == '0) begin
      len_eff = mcs_pkg::LEN_BITS'(1);
    end else if (tuple_length > mcs_pkg::LEN_BITS'(MAX_K)) begin
      len_eff = mcs_pkg::LEN_BITS'(MAX_K);
    end else begin
      len_eff = tuple_length;
    end
  end

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  assign ctrl.step    = accept && (req.cmd == mcs_pkg::CMD_STEP);
  assign ctrl.load    = accept && (req.cmd == mcs_pkg::CMD_LOAD);
  assign ctrl.idx     = req.elem_index;
  assign ctrl.val     = req.elem_value;
  assign ctrl.max_val = mcs_pkg::LANE_BITS'(max_wide[ELEM_BITS-1:0]);
  assign ctrl.len     = len_eff;

  assign below_chain[MAX_K] = 1'b0;
  assign fill_chain[0]      = '0;

  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    mcs_cell #(
      .IDX       (i),
      .ELEM_BITS (ELEM_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .below_right (below_chain[i+1]),
      .below_left  (below_chain[i]),
      .fill_in     (fill_chain[i]),
      .fill_out    (fill_chain[i+1]),
      .lane_next   (lanes_next[i])
    );
    // positions beyond the tuple length read as zero
    assign lanes_out[i] = (mcs_pkg::LEN_BITS'(i) < len_eff) ? lanes_next[i] : '0;
  end

  assign done = ctrl.step && !below_chain[0];

  assign rsp_valid_next = accept || (rsp_valid && rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.tuple_packed <= 64'(lanes_out);
      rsp.status       <= done ? mcs_pkg::STATUS_DONE : mcs_pkg::STATUS_OK;
    end
  end

  // current element values, for checking only
  for (genvar j = 0; j < MAX_K; j++) begin : g_now
    assign lanes_now[j] = mcs_pkg::LANE_BITS'(g_cell[j].u_cell.elem);
  end

  `MCS_ASSERT_NEXT(a_done_holds_tuple, done, $stable(lanes_now), "finished step changed the tuple")
  `MCS_ASSERT_NEXT(a_step_moves_tuple, ctrl.step && !done, lanes_now != $past(lanes_now), "step left the tuple unchanged")
  `MCS_ASSERT_NEXT(a_accept_gives_rsp, accept, rsp_valid, "accepted request produced no response")

endmodule

// ----- rtl/mcs_cell.sv -----
// ----------------------------------------------------------------------------
// Multiset combination stepper cell
// Holds one tuple element; finds the pivot and takes the fill from its left.
// ----------------------------------------------------------------------------
module mcs_cell #(
  parameter int IDX       = 0,
  parameter int ELEM_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mcs_pkg::cell_ctrl_t           ctrl,
  input  logic                          below_right,
  output logic                          below_left,
  input  mcs_pkg::fill_t                fill_in,
  output mcs_pkg::fill_t                fill_out,
  output logic [mcs_pkg::LANE_BITS-1:0] lane_next
);

  logic [ELEM_BITS-1:0] elem;
  logic [ELEM_BITS-1:0] elem_next;
  logic [ELEM_BITS-1:0] elem_inc;
  logic                 active;
  logic                 below;
  logic                 pivot;

  assign active   = mcs_pkg::LEN_BITS'(IDX) < ctrl.len;
  assign below    = active && (mcs_pkg::LANE_BITS'(elem) < ctrl.max_val);
  assign pivot    = below && !below_right;
  assign below_left = below || below_right;
  assign elem_inc = elem + ELEM_BITS'(1);

  assign fill_out.on  = active && (pivot || fill_in.on);
  assign fill_out.val = pivot ? mcs_pkg::LANE_BITS'(elem_inc) : fill_in.val;

  always_comb begin
    elem_next = elem;
    if (ctrl.load && active && (ctrl.idx == mcs_pkg::IDX_BITS'(IDX))) begin
      elem_next = ctrl.val[ELEM_BITS-1:0];
    end else if (ctrl.step && pivot) begin
      elem_next = elem_inc;
    end else if (ctrl.step && active && fill_in.on) begin
      elem_next = fill_in.val[ELEM_BITS-1:0];
    end
  end

  assign lane_next = mcs_pkg::LANE_BITS'(elem_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      elem <= '0;
    end else begin
      elem <= elem_next;
    end
  end

endmodule
